// ===== design/gmt_pkg.sv =====
// shared types and codes for the gossip membership table
// no dependencies; imported by every module of the block
package gmt_pkg;

    localparam int unsigned ID_W    = 32;
    localparam int unsigned PORT_W  = 16;
    localparam int unsigned BEAT_W  = 32;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W   = 32;

    // input operation codes
    localparam logic FUNC_MERGE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_MERGE  = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // merge status codes
    localparam logic [1:0] ST_UPDATED   = 2'd0;
    localparam logic [1:0] ST_UNCHANGED = 2'd1;
    localparam logic [1:0] ST_ADDED     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_PORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

    typedef struct packed {
        logic              func;
        logic [ID_W-1:0]   peer_id;
        logic [PORT_W-1:0] peer_port;
        logic [BEAT_W-1:0] peer_heartbeat;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        status;
        logic [ID_W-1:0]   member_id;
        logic [PORT_W-1:0] member_port;
        logic [CNT_W-1:0]  member_count;
        logic [BEAT_W-1:0] local_beat;
        logic              last;
    } out_word_t;

    // one stored table entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [BEAT_W-1:0] beat;
        logic [BEAT_W-1:0] stamp;
    } entry_t;

endpackage

// ===== design/gmt_entry_ram.sv =====
// entry memory of the membership table: one write port, one registered read port
// depends on gmt_pkg for the entry type
module gmt_entry_ram #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  gmt_pkg::entry_t          wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output gmt_pkg::entry_t          rd_data
);
    import gmt_pkg::*;

    entry_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/gmt_out_buf.sv =====
// output register holding one result word until the consumer takes it
// depends on gmt_pkg for the result word type
module gmt_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gmt_pkg::out_word_t push_word,
    output logic               ready,
    output logic               out_valid,
    input  logic               out_stall,
    output gmt_pkg::out_word_t out_word
);
    import gmt_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    // room when empty or the held word leaves this cycle
    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            word_reg <= push_word;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ready)
        else $error("word pushed into a full output register");
`endif

endmodule

// ===== design/gossip_membership_table.sv =====
// gossip membership table: a merge reads entries 1..TABLE_DEPTH-1 through the entry
// memory in turn, each through a read state and a check state; a tick walks the same
// entries and emits a remove result for each aged-out entry before its final tick result;
// one word is worked on at a time; each result waits while the output register is held.
// reset: only entry zero valid, counter zero, no memory clearing pass.
// depends on gmt_pkg, gmt_entry_ram, gmt_out_buf
module gossip_membership_table #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  gmt_pkg::in_word_t                in_word,
    output logic                             out_valid,
    input  logic                             out_stall,
    output gmt_pkg::out_word_t               out_word,
    input  logic                             cfg_we,
    input  logic [gmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gmt_pkg::CFG_W-1:0]        cfg_data
);
    import gmt_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned TCNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CHK  = 5'b00100,
        S_FIN  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    func_reg, func_next;
    logic [ID_W-1:0]         pid_reg, pid_next;
    logic [PORT_W-1:0]       pport_reg, pport_next;
    logic [BEAT_W-1:0]       pbeat_reg, pbeat_next;
    logic                    hit_found_reg, hit_found_next;
    logic                    hit_zero_reg, hit_zero_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    entry_t                  hit_entry_reg, hit_entry_next;
    logic                    free_found_reg, free_found_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;
    logic [TABLE_DEPTH-1:0]  valid_reg, valid_next;
    logic [TCNT_W-1:0]       count_reg, count_next;
    logic [BEAT_W-1:0]       lc_reg, lc_next;
    logic [BEAT_W-1:0]       self_beat_reg, self_beat_next;
    out_word_t               word_reg, word_next;
    logic                    done_reg, done_next;
    logic [ID_W-1:0]         self_id_reg;
    logic [PORT_W-1:0]       self_port_reg;
    logic [PORT_W-1:0]       timeout_reg;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    entry_t                  wr_data;
    entry_t                  rd_data;
    logic                    push;
    logic                    buf_ready;
    logic [BEAT_W-1:0]       age;

    gmt_entry_ram #(.DEPTH(TABLE_DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    gmt_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (word_reg),
        .ready     (buf_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign push     = (state_reg == S_EMIT) && buf_ready;
    assign age      = lc_reg - rd_data.stamp;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg   <= ID_W'(1);
            self_port_reg <= '0;
            timeout_reg   <= PORT_W'(20);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SELF_ID:   self_id_reg   <= cfg_data[ID_W-1:0];
                CFG_SELF_PORT: self_port_reg <= cfg_data[PORT_W-1:0];
                CFG_TIMEOUT:   timeout_reg   <= cfg_data[PORT_W-1:0];
                default:       ;
            endcase
        end
    end

    // sequencer: read, check, finish, emit
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        func_next       = func_reg;
        pid_next        = pid_reg;
        pport_next      = pport_reg;
        pbeat_next      = pbeat_reg;
        hit_found_next  = hit_found_reg;
        hit_zero_next   = hit_zero_reg;
        hit_idx_next    = hit_idx_reg;
        hit_entry_next  = hit_entry_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        lc_next         = lc_reg;
        self_beat_next  = self_beat_reg;
        word_next       = word_reg;
        done_next       = done_reg;
        wr_en           = 1'b0;
        wr_addr         = free_idx_reg;
        wr_data         = '{id: pid_reg, port: pport_reg, beat: pbeat_reg, stamp: lc_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next       = in_word.func;
                    pid_next        = in_word.peer_id;
                    pport_next      = in_word.peer_port;
                    pbeat_next      = in_word.peer_heartbeat;
                    idx_next        = IDX_W'(1);
                    free_found_next = 1'b0;
                    // entry zero always valid and holds self
                    hit_zero_next   = (in_word.peer_id == self_id_reg);
                    hit_found_next  = (in_word.peer_id == self_id_reg);
                    if (in_word.func == FUNC_TICK)
                    begin
                        lc_next        = lc_reg + 1'b1;
                        self_beat_next = lc_reg + 1'b1;
                    end
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (func_reg == FUNC_MERGE)
                begin
                    // first matching valid entry, first free slot
                    if (valid_reg[idx_reg] && !hit_found_reg && rd_data.id == pid_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = idx_reg;
                        hit_entry_next = rd_data;
                    end
                    if (!valid_reg[idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (valid_reg[idx_reg] && age > {16'b0, timeout_reg})
                begin
                    // aged out: drop it and report
                    valid_next[idx_reg] = 1'b0;
                    count_next = count_reg - 1'b1;
                    word_next  = '{kind: KIND_REMOVE, status: ST_UPDATED,
                                   member_id: rd_data.id, member_port: rd_data.port,
                                   member_count: CNT_W'(count_reg - 1'b1),
                                   local_beat: lc_reg, last: 1'b0};
                    done_next  = 1'b0;
                    state_next = S_EMIT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    word_next  = '{kind: KIND_TICK, status: ST_UPDATED,
                                   member_id: self_id_reg, member_port: self_port_reg,
                                   member_count: CNT_W'(count_reg),
                                   local_beat: lc_reg, last: 1'b1};
                    done_next  = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                word_next = '{kind: KIND_MERGE, status: ST_FULL,
                              member_id: pid_reg, member_port: pport_reg,
                              member_count: CNT_W'(count_reg),
                              local_beat: lc_reg, last: 1'b1};
                if (hit_zero_reg)
                begin
                    word_next.status = ST_UNCHANGED;
                    if (pbeat_reg > self_beat_reg)
                    begin
                        self_beat_next   = pbeat_reg;
                        word_next.status = ST_UPDATED;
                    end
                end
                else if (hit_found_reg)
                begin
                    word_next.status = ST_UNCHANGED;
                    if (pbeat_reg > hit_entry_reg.beat)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = hit_idx_reg;
                        wr_data = '{id: hit_entry_reg.id, port: hit_entry_reg.port,
                                    beat: pbeat_reg, stamp: lc_reg};
                        word_next.status = ST_UPDATED;
                    end
                end
                else if (free_found_reg)
                begin
                    // insert into lowest free slot
                    wr_en = 1'b1;
                    valid_next[free_idx_reg] = 1'b1;
                    count_next = count_reg + 1'b1;
                    word_next.status       = ST_ADDED;
                    word_next.member_count = CNT_W'(count_reg + 1'b1);
                end
                done_next  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (buf_ready)
                begin
                    if (done_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        word_next  = '{kind: KIND_TICK, status: ST_UPDATED,
                                       member_id: self_id_reg, member_port: self_port_reg,
                                       member_count: CNT_W'(count_reg),
                                       local_beat: lc_reg, last: 1'b1};
                        done_next  = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            func_reg       <= FUNC_MERGE;
            hit_found_reg  <= 1'b0;
            hit_zero_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= TABLE_DEPTH'(1);
            count_reg      <= TCNT_W'(1);
            lc_reg         <= '0;
            self_beat_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            func_reg       <= func_next;
            hit_found_reg  <= hit_found_next;
            hit_zero_reg   <= hit_zero_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            lc_reg         <= lc_next;
            self_beat_reg  <= self_beat_next;
            done_reg       <= done_next;
        end
    end

    // payload holding registers
    always_ff @(posedge clk)
    begin
        pid_reg       <= pid_next;
        pport_reg     <= pport_next;
        pbeat_reg     <= pbeat_next;
        hit_idx_reg   <= hit_idx_next;
        hit_entry_reg <= hit_entry_next;
        free_idx_reg  <= free_idx_next;
        word_reg      <= word_next;
    end

`ifndef SYNTHESIS
    a_self_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0])
        else $error("entry zero lost its valid bit");
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == TCNT_W'($countones(valid_reg)))
        else $error("member count disagrees with valid bits");
    a_write_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == S_FIN && func_reg == FUNC_MERGE)
        else $error("entry memory written outside merge finish");
    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_word.func == FUNC_TICK) |=> lc_reg == $past(lc_reg) + 1'b1)
        else $error("local counter did not advance on tick");
`endif

endmodule
